// ===== design/positional_list_store_assert.svh =====
// Assertion macros for the positional list store.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLS_ASSERT_NOW(lbl, ante, cons, msg)
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/pls_pkg.sv =====
`timescale 1ns / 1ps
package pls_pkg;

    localparam int IDX_W     = 6;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 6;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_END   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_END   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_POS   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DISPLAY   = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last_idx;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== design/pls_cell.sv =====
`timescale 1ns / 1ps
module pls_cell #(
    parameter int INDEX = 0
) (
    input  logic                        aclk,
    input  pls_pkg::cell_ctrl_t         ctrl,
    input  logic [pls_pkg::VAL_W-1:0]   left_data,
    input  logic [pls_pkg::VAL_W-1:0]   right_data,
    input  logic [pls_pkg::VAL_W-1:0]   head_data,
    output logic [pls_pkg::VAL_W-1:0]   data
);

    localparam logic [pls_pkg::IDX_W-1:0] MY_IDX = pls_pkg::IDX_W'(INDEX);

    logic [pls_pkg::VAL_W-1:0] data_reg;
    logic [pls_pkg::VAL_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            pls_pkg::CELL_INS: begin
                if (MY_IDX == ctrl.idx) begin
                    data_next = ctrl.value;
                end else if (MY_IDX > ctrl.idx) begin
                    data_next = left_data;
                end
            end
            pls_pkg::CELL_DEL: begin
                if (MY_IDX >= ctrl.idx) begin
                    data_next = right_data;
                end
            end
            pls_pkg::CELL_ROT: begin
                if (MY_IDX == ctrl.last_idx) begin
                    data_next = head_data;
                end else if (MY_IDX < ctrl.last_idx) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/pls_chain.sv =====
`timescale 1ns / 1ps
module pls_chain #(
    parameter int CAPACITY = 32
) (
    input  logic                        aclk,
    input  pls_pkg::cell_ctrl_t         ctrl,
    output logic [pls_pkg::VAL_W-1:0]   head_data,
    output logic [pls_pkg::VAL_W-1:0]   sel_data
);

    logic [pls_pkg::VAL_W-1:0] cell_data [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [pls_pkg::VAL_W-1:0] left_in;
            logic [pls_pkg::VAL_W-1:0] right_in;
            if (gi == 0) begin : g_first
                assign left_in = ctrl.value;
            end else begin : g_mid_l
                assign left_in = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_in = cell_data[0];
            end else begin : g_mid_r
                assign right_in = cell_data[gi+1];
            end
            pls_cell #(
                .INDEX(gi)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .left_data (left_in),
                .right_data(right_in),
                .head_data (cell_data[0]),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_comb begin
        sel_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (ctrl.idx == pls_pkg::IDX_W'(i)) begin
                sel_data = sel_data | cell_data[i];
            end
        end
    end

    assign head_data = cell_data[0];

endmodule

// ===== design/positional_list_store.sv =====
`timescale 1ns / 1ps
// An edit's result is registered straight into the output register, so edits run at one per
// cycle while the result side keeps up and no display is running.
// A display enters the display state, then emits the entries in order as the cell row rotates once.
// aresetn is synchronous and active low: it clears the length, the sequencer and the output
// valid; the stored entries are not cleared.
`include "positional_list_store_assert.svh"
module positional_list_store #(
    parameter int CAPACITY = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value [31:0], position [37:32], zero padding above
    input  logic [pls_pkg::S_TDATA_W-1:0]       s_tdata,
    // kind [2:0]
    input  logic [pls_pkg::KIND_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // value_res [31:0], position_res [37:32], length [43:38], zero padding above
    output logic [pls_pkg::M_TDATA_W-1:0]       m_tdata,
    // status [1:0]
    output logic [pls_pkg::STATUS_W-1:0]        m_tuser,
    output logic                                m_tlast
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = pls_pkg::POS_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DISP = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [LEN_W-1:0]               cnt_reg, cnt_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [pls_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [pls_pkg::VAL_W-1:0]      value_reg, value_next;
    logic [pls_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [pls_pkg::POS_W-1:0]      olen_reg, olen_next;
    logic                           last_reg, last_next;

    pls_pkg::cell_ctrl_t            ctrl;
    logic [pls_pkg::VAL_W-1:0]      head_data;
    logic [pls_pkg::VAL_W-1:0]      sel_data;

    logic                           out_free;
    logic                           accept;
    logic                           ins_ok;
    logic [pls_pkg::KIND_W-1:0]     kind;
    logic [pls_pkg::VAL_W-1:0]      in_value;
    logic [EXT_W-1:0]               in_pos;
    logic [EXT_W-1:0]               len_ext;
    logic [EXT_W-1:0]               pos_eff;
    logic [EXT_W-1:0]               new_len;
    logic [EXT_W-1:0]               cnt_ext;
    logic [7:0]                     wide_tmp;
    logic [7:0]                     wide_pos;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign kind     = s_tuser;
    assign in_value = s_tdata[31:0];
    assign in_pos   = EXT_W'(s_tdata[37:32]);
    assign len_ext  = EXT_W'(len_reg);
    assign cnt_ext  = EXT_W'(cnt_reg);

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        value_next    = value_reg;
        pos_next      = pos_reg;
        olen_next     = olen_reg;
        last_next     = last_reg;
        ctrl.op       = pls_pkg::CELL_HOLD;
        ctrl.idx      = '0;
        ctrl.last_idx = '0;
        ctrl.value    = in_value;
        ins_ok        = 1'b0;
        pos_eff       = '0;
        new_len       = len_ext;
        wide_tmp      = '0;
        wide_pos      = '0;

        if (accept) begin
            case (kind)
                pls_pkg::KIND_INS_FRONT, pls_pkg::KIND_INS_END, pls_pkg::KIND_INS_POS: begin
                    m_tvalid_next = 1'b1;
                    value_next    = in_value;
                    pos_next      = '0;
                    last_next     = 1'b1;
                    wide_tmp      = 8'(len_ext);
                    olen_next     = wide_tmp[5:0];
                    if (kind == pls_pkg::KIND_INS_FRONT) begin
                        pos_eff = EXT_W'(1);
                    end else if (kind == pls_pkg::KIND_INS_END) begin
                        pos_eff = len_ext + EXT_W'(1);
                    end else begin
                        pos_eff = in_pos;
                    end
                    if (len_ext == EXT_W'(CAPACITY)) begin
                        status_next = pls_pkg::STATUS_FULL;
                    end else if (pos_eff == '0 || pos_eff > len_ext + EXT_W'(1)) begin
                        status_next = pls_pkg::STATUS_RANGE;
                    end else begin
                        ins_ok      = 1'b1;
                        status_next = pls_pkg::STATUS_OK;
                        new_len     = len_ext + EXT_W'(1);
                        len_next    = new_len[LEN_W-1:0];
                        wide_tmp    = 8'(new_len);
                        olen_next   = wide_tmp[5:0];
                        wide_pos    = 8'(pos_eff);
                        pos_next    = wide_pos[5:0];
                        wide_pos    = 8'(pos_eff - EXT_W'(1));
                        ctrl.op     = pls_pkg::CELL_INS;
                        ctrl.idx    = wide_pos[pls_pkg::IDX_W-1:0];
                    end
                end
                pls_pkg::KIND_DEL_FRONT, pls_pkg::KIND_DEL_END, pls_pkg::KIND_DEL_POS: begin
                    m_tvalid_next = 1'b1;
                    value_next    = '0;
                    pos_next      = '0;
                    last_next     = 1'b1;
                    wide_tmp      = 8'(len_ext);
                    olen_next     = wide_tmp[5:0];
                    if (kind == pls_pkg::KIND_DEL_FRONT) begin
                        pos_eff = EXT_W'(1);
                    end else if (kind == pls_pkg::KIND_DEL_END) begin
                        pos_eff = len_ext;
                    end else begin
                        pos_eff = in_pos;
                    end
                    wide_pos = 8'(pos_eff - EXT_W'(1));
                    ctrl.idx = wide_pos[pls_pkg::IDX_W-1:0];
                    if (len_ext == '0) begin
                        status_next = pls_pkg::STATUS_EMPTY;
                    end else if (pos_eff == '0 || pos_eff > len_ext) begin
                        status_next = pls_pkg::STATUS_RANGE;
                    end else begin
                        status_next = pls_pkg::STATUS_OK;
                        value_next  = sel_data;
                        new_len     = len_ext - EXT_W'(1);
                        len_next    = new_len[LEN_W-1:0];
                        wide_tmp    = 8'(new_len);
                        olen_next   = wide_tmp[5:0];
                        wide_pos    = 8'(pos_eff);
                        pos_next    = wide_pos[5:0];
                        ctrl.op     = pls_pkg::CELL_DEL;
                    end
                end
                pls_pkg::KIND_DISPLAY: begin
                    if (len_ext == '0) begin
                        m_tvalid_next = 1'b1;
                        status_next   = pls_pkg::STATUS_EMPTY;
                        value_next    = '0;
                        pos_next      = '0;
                        olen_next     = '0;
                        last_next     = 1'b1;
                    end else begin
                        state_next = ST_DISP;
                        cnt_next   = '0;
                    end
                end
                default: begin
                    m_tvalid_next = m_tvalid_reg && !m_tready;
                end
            endcase
        end else if (state_reg == ST_DISP && out_free) begin
            wide_tmp      = 8'(len_ext - EXT_W'(1));
            ctrl.op       = pls_pkg::CELL_ROT;
            ctrl.last_idx = wide_tmp[pls_pkg::IDX_W-1:0];
            m_tvalid_next = 1'b1;
            status_next   = pls_pkg::STATUS_OK;
            value_next    = head_data;
            wide_pos      = 8'(cnt_ext + EXT_W'(1));
            pos_next      = wide_pos[5:0];
            wide_tmp      = 8'(len_ext);
            olen_next     = wide_tmp[5:0];
            last_next     = (cnt_ext + EXT_W'(1) == len_ext);
            cnt_next      = cnt_reg + LEN_W'(1);
            if (cnt_ext + EXT_W'(1) == len_ext) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        olen_reg   <= olen_next;
        last_reg   <= last_next;
    end

    pls_chain #(
        .CAPACITY(CAPACITY)
    ) u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .head_data(head_data),
        .sel_data (sel_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, olen_reg, pos_reg, value_reg};

    `PLS_ASSERT_NOW(a_len_bound, 1'b1, len_ext <= EXT_W'(CAPACITY), "length above capacity")
    `PLS_ASSERT_NOW(a_disp_nonempty, state_reg == ST_DISP, len_reg != '0, "display of empty list")
    `PLS_ASSERT_NOW(a_disp_cnt, state_reg == ST_DISP, cnt_reg < len_reg, "display ran past end")
    `PLS_ASSERT_NEXT(a_ins_grow, ins_ok, len_reg == $past(len_reg) + LEN_W'(1), "insert lost")

endmodule
